// ===== design/cln_pkg.sv =====
// Shared types and constants for the character LCD nibble interface.
// No dependencies; imported by cln_seq and char_lcd_nibble_interface_core.
package cln_pkg;

  // Command codes carried by each input item
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam int unsigned CfgIndexWidth = 3;
  localparam logic [CfgIndexWidth-1:0] CFG_MIRROR_PORT  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_ENABLE_WIDTH = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_NIBBLE_GAP   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_CLEAR_WAIT   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_POWER_WAIT   = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CFG_FIRST_GAP    = 3'd5;

  // Register reset values
  localparam logic        MIRROR_PORT_RST  = 1'b1;
  localparam logic [7:0]  ENABLE_WIDTH_RST = 8'd1;
  localparam logic [15:0] NIBBLE_GAP_RST   = 16'd100;
  localparam logic [15:0] CLEAR_WAIT_RST   = 16'd3000;
  localparam logic [15:0] POWER_WAIT_RST   = 16'd30000;
  localparam logic [15:0] FIRST_GAP_RST    = 16'd4100;

  // Sequencer steps: write, clear, and the power-on init chain
  typedef enum logic [5:0] {
    STEP_IDLE           = 6'd0,
    STEP_WRITE          = 6'd1,
    STEP_CLR_BYTE       = 6'd2,
    STEP_CLR_WAIT       = 6'd3,
    STEP_POWER          = 6'd4,
    STEP_NIB_0          = 6'd5,
    STEP_NIB_1          = 6'd6,
    STEP_NIB_2          = 6'd7,
    STEP_NIB_3          = 6'd8,
    STEP_INIT_FUNC      = 6'd9,
    STEP_INIT_OFF       = 6'd10,
    STEP_INIT_CLR_BYTE  = 6'd11,
    STEP_INIT_CLR_WAIT  = 6'd12,
    STEP_INIT_MODE      = 6'd13,
    STEP_INIT_ON        = 6'd14
  } step_t;

  // Bytes sent during init and clear
  localparam logic [7:0] BYTE_FUNC_SET  = 8'b0010_1000;
  localparam logic [7:0] BYTE_DISP_OFF  = 8'b0000_1000;
  localparam logic [7:0] BYTE_CLEAR     = 8'b0000_0001;
  localparam logic [7:0] BYTE_ENTRY     = 8'b0000_0110;
  localparam logic [7:0] BYTE_DISP_ON   = 8'b0000_1111;
  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;

  // Configuration register set
  typedef struct packed {
    logic        mirror_port;
    logic [7:0]  enable_width;
    logic [15:0] nibble_gap;
    logic [15:0] clear_wait;
    logic [15:0] power_wait;
    logic [15:0] first_gap;
  } cfg_t;

  // Input item
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       register_select;
  } lcd_in_t;

  // Result item
  typedef struct packed {
    logic       rs_pin;
    logic       enable_pin;
    logic [3:0] data_nibble;
    logic [3:0] port_nibble;
    logic       busy_res;
    logic       rejected;
  } lcd_out_t;

endpackage

// ===== design/char_lcd_nibble_interface_core.sv =====
// Top level of the character LCD 4-bit interface: config registers and result stage.
// Depends on cln_pkg and cln_seq.
//
// Each item (a one-microsecond tick or a write, init or clear command) gives one
// result, registered in the cycle after it is taken, so the block sustains one item per
// clock; the only hold-up is a result left waiting in the single output register.
// Results report the LCD pin levels after the item. Commands that arrive while a
// sequence is running are dropped and flagged as rejected. Write the configuration
// registers only while no sequence is running.
module char_lcd_nibble_interface_core import cln_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  lcd_in_t                  cmd_item,
  output logic                     res_valid,
  input  logic                     res_stall,
  output lcd_out_t                 res_item,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [15:0]              cfg_data
);

  cfg_t     cfg;
  lcd_out_t res_next;
  logic     accept;

  // Input transfer when the result stage is free or being emptied
  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;

  cln_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .go   (accept),
    .item (cmd_item),
    .cfg  (cfg),
    .res  (res_next)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mirror_port  <= MIRROR_PORT_RST;
      cfg.enable_width <= ENABLE_WIDTH_RST;
      cfg.nibble_gap   <= NIBBLE_GAP_RST;
      cfg.clear_wait   <= CLEAR_WAIT_RST;
      cfg.power_wait   <= POWER_WAIT_RST;
      cfg.first_gap    <= FIRST_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIRROR_PORT:  cfg.mirror_port  <= cfg_data[0];
        CFG_ENABLE_WIDTH: cfg.enable_width <= cfg_data[7:0];
        CFG_NIBBLE_GAP:   cfg.nibble_gap   <= cfg_data;
        CFG_CLEAR_WAIT:   cfg.clear_wait   <= cfg_data;
        CFG_POWER_WAIT:   cfg.power_wait   <= cfg_data;
        CFG_FIRST_GAP:    cfg.first_gap    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Result stage: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!cmd_stall) begin
      res_valid <= cmd_valid;
    end
  end

  // Result stage: payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_item <= res_next;
    end
  end

endmodule

// ===== design/cln_seq.sv =====
// Sequencer for the LCD nibble interface: state registers and per-item update.
// Depends on cln_pkg.
module cln_seq import cln_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     go,
  input  lcd_in_t  item,
  input  cfg_t     cfg,
  output lcd_out_t res
);

  typedef struct packed {
    step_t       step;
    logic [15:0] wait_count;
    logic [7:0]  held_byte;
    logic        held_select;
    logic        low_phase;
    logic        rs;
    logic        en;
    logic [3:0]  nib;
  } seq_state_t;

  seq_state_t st;
  seq_state_t st_next;
  logic       rejected;

  // Enable pulse length, zero read as one
  function automatic logic [15:0] pulse_len(input cfg_t c);
    pulse_len = (c.enable_width == 8'd0) ? 16'd1 : {8'd0, c.enable_width};
  endfunction

  // Post-pulse gap, zero read as one
  function automatic logic [15:0] gap_len(input cfg_t c);
    gap_len = (c.nibble_gap == 16'd0) ? 16'd1 : c.nibble_gap;
  endfunction

  function automatic step_t next_step(input step_t s);
    case (s)
      STEP_IDLE, STEP_WRITE, STEP_CLR_WAIT, STEP_INIT_ON: next_step = STEP_IDLE;
      STEP_CLR_BYTE:      next_step = STEP_CLR_WAIT;
      STEP_POWER:         next_step = STEP_NIB_0;
      STEP_NIB_0:         next_step = STEP_NIB_1;
      STEP_NIB_1:         next_step = STEP_NIB_2;
      STEP_NIB_2:         next_step = STEP_NIB_3;
      STEP_NIB_3:         next_step = STEP_INIT_FUNC;
      STEP_INIT_FUNC:     next_step = STEP_INIT_OFF;
      STEP_INIT_OFF:      next_step = STEP_INIT_CLR_BYTE;
      STEP_INIT_CLR_BYTE: next_step = STEP_INIT_CLR_WAIT;
      STEP_INIT_CLR_WAIT: next_step = STEP_INIT_MODE;
      STEP_INIT_MODE:     next_step = STEP_INIT_ON;
      default:            next_step = STEP_IDLE;
    endcase
  endfunction

  function automatic logic [7:0] fixed_byte(input step_t s);
    case (s)
      STEP_INIT_FUNC: fixed_byte = BYTE_FUNC_SET;
      STEP_INIT_OFF:  fixed_byte = BYTE_DISP_OFF;
      STEP_INIT_MODE: fixed_byte = BYTE_ENTRY;
      STEP_INIT_ON:   fixed_byte = BYTE_DISP_ON;
      default:        fixed_byte = BYTE_CLEAR;
    endcase
  endfunction

  function automatic logic [3:0] reverse4(input logic [3:0] v);
    reverse4 = {v[0], v[1], v[2], v[3]};
  endfunction

  // Enter a step; a zero-length wait falls straight through to the following step
  function automatic seq_state_t enter_step(input seq_state_t cur, input step_t s,
                                            input cfg_t c);
    seq_state_t n;
    step_t      r;
    n = cur;
    r = s;
    if (r == STEP_POWER && c.power_wait == 16'd0) begin
      r = STEP_NIB_0;
    end else if (r == STEP_CLR_WAIT && c.clear_wait == 16'd0) begin
      r = STEP_IDLE;
    end else if (r == STEP_INIT_CLR_WAIT && c.clear_wait == 16'd0) begin
      r = STEP_INIT_MODE;
    end
    n.step = r;
    n.en   = 1'b0;
    case (r)
      STEP_POWER: begin
        n.wait_count = c.power_wait;
      end
      STEP_CLR_WAIT, STEP_INIT_CLR_WAIT: begin
        n.wait_count = c.clear_wait;
      end
      STEP_NIB_0, STEP_NIB_1, STEP_NIB_2, STEP_NIB_3: begin
        n.rs         = 1'b0;
        n.low_phase  = 1'b0;
        n.nib        = (r == STEP_NIB_3) ? NIB_FOUR_BIT : NIB_WAKE;
        n.en         = 1'b1;
        n.wait_count = pulse_len(c);
      end
      STEP_WRITE: begin
        n.low_phase  = 1'b0;
        n.rs         = n.held_select;
        n.nib        = n.held_byte[7:4];
        n.en         = 1'b1;
        n.wait_count = pulse_len(c);
      end
      STEP_CLR_BYTE, STEP_INIT_FUNC, STEP_INIT_OFF, STEP_INIT_CLR_BYTE,
      STEP_INIT_MODE, STEP_INIT_ON: begin
        n.held_select = 1'b0;
        n.held_byte   = fixed_byte(r);
        n.low_phase   = 1'b0;
        n.rs          = 1'b0;
        n.nib         = n.held_byte[7:4];
        n.en          = 1'b1;
        n.wait_count  = pulse_len(c);
      end
      default: begin
        n.step       = STEP_IDLE;
        n.wait_count = 16'd0;
      end
    endcase
    enter_step = n;
  endfunction

  // One microsecond of progress
  function automatic seq_state_t tick_step(input seq_state_t cur, input cfg_t c);
    seq_state_t  n;
    logic [15:0] w;
    n = cur;
    w = (cur.wait_count != 16'd0) ? cur.wait_count - 16'd1 : 16'd0;
    if (cur.step != STEP_IDLE) begin
      n.wait_count = w;
      if (w == 16'd0) begin
        if (cur.en) begin
          // end of enable pulse: start the gap
          n.en = 1'b0;
          if (cur.step == STEP_NIB_0) begin
            if (c.first_gap == 16'd0) begin
              n = enter_step(n, STEP_NIB_1, c);
            end else begin
              n.wait_count = c.first_gap;
            end
          end else begin
            n.wait_count = gap_len(c);
          end
        end else if (cur.step inside {STEP_WRITE, STEP_CLR_BYTE, STEP_INIT_FUNC,
                                      STEP_INIT_OFF, STEP_INIT_CLR_BYTE,
                                      STEP_INIT_MODE, STEP_INIT_ON}
                     && !cur.low_phase) begin
          // second half of a byte
          n.low_phase  = 1'b1;
          n.nib        = cur.held_byte[3:0];
          n.en         = 1'b1;
          n.wait_count = pulse_len(c);
        end else begin
          n = enter_step(n, next_step(cur.step), c);
        end
      end
    end
    tick_step = n;
  endfunction

  // Next state
  always_comb begin
    st_next  = st;
    rejected = 1'b0;
    if (go) begin
      case (item.cmd)
        CMD_TICK: begin
          st_next = tick_step(st, cfg);
        end
        CMD_WRITE, CMD_INIT, CMD_CLEAR: begin
          if (st.step != STEP_IDLE) begin
            rejected = 1'b1;
          end else if (item.cmd == CMD_WRITE) begin
            st_next             = st;
            st_next.held_byte   = item.data_byte;
            st_next.held_select = item.register_select;
            st_next             = enter_step(st_next, STEP_WRITE, cfg);
          end else if (item.cmd == CMD_INIT) begin
            st_next = enter_step(st, STEP_POWER, cfg);
          end else begin
            st_next = enter_step(st, STEP_CLR_BYTE, cfg);
          end
        end
        default: begin
          st_next = st;
        end
      endcase
    end
  end

  // Result for the item being taken
  always_comb begin
    res.rs_pin      = st_next.rs;
    res.enable_pin  = st_next.en;
    res.data_nibble = st_next.nib;
    res.port_nibble = cfg.mirror_port ? reverse4(st_next.nib) : st_next.nib;
    res.busy_res    = (st_next.step != STEP_IDLE);
    res.rejected    = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for char_lcd_nibble_interface_core: predicts the LCD pin levels
// per transfer and checks every result, across several timing settings and idle patterns.
// Depends on cln_pkg and the design sources only.
module testbench;
  import cln_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cmd_valid = 1'b0;
  logic                     cmd_stall;
  lcd_in_t                  cmd_item = '0;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  lcd_out_t                 res_item;
  logic                     cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [15:0]              cfg_data = '0;

  char_lcd_nibble_interface_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stimulus waiting to go out, and pin levels still owed by the block
  lcd_in_t     cmd_backlog[$];
  lcd_out_t    pin_levels_due[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_taken = 0;
  int unsigned results_checked = 0;
  int unsigned drops_seen = 0;
  int unsigned mismatches = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  // Predictor state: settings, sequencer and pin levels
  cfg_t        lcd_cfg;
  step_t       lcd_step;
  logic [15:0] wait_left;
  logic [7:0]  held_byte;
  logic        held_sel;
  logic        low_half;
  logic        rs_lvl;
  logic        en_lvl;
  logic [3:0]  nib_lvl;

  function automatic void reset_predictor();
    lcd_cfg.mirror_port  = MIRROR_PORT_RST;
    lcd_cfg.enable_width = ENABLE_WIDTH_RST;
    lcd_cfg.nibble_gap   = NIBBLE_GAP_RST;
    lcd_cfg.clear_wait   = CLEAR_WAIT_RST;
    lcd_cfg.power_wait   = POWER_WAIT_RST;
    lcd_cfg.first_gap    = FIRST_GAP_RST;
    lcd_step  = STEP_IDLE;
    wait_left = '0;
    held_byte = '0;
    held_sel  = 1'b0;
    low_half  = 1'b0;
    rs_lvl    = 1'b0;
    en_lvl    = 1'b0;
    nib_lvl   = '0;
  endfunction

  // Single writes and clear-wait ends return to idle; the init chain runs on
  function automatic logic [5:0] following_step(logic [5:0] s);
    if (s == STEP_WRITE || s == STEP_CLR_WAIT || s >= STEP_INIT_ON) return STEP_IDLE;
    return s + 6'd1;
  endfunction

  function automatic bit sends_byte(logic [5:0] s);
    return s == STEP_WRITE || s == STEP_CLR_BYTE || (s >= STEP_INIT_FUNC &&
           s <= STEP_INIT_CLR_BYTE) || s == STEP_INIT_MODE || s == STEP_INIT_ON;
  endfunction

  function automatic void raise_enable(logic [3:0] nib);
    nib_lvl   = nib;
    en_lvl    = 1'b1;
    wait_left = (lcd_cfg.enable_width == 0) ? 16'd1 : {8'd0, lcd_cfg.enable_width};
  endfunction

  // Enter a step; zero-length waits fall straight through to the next one
  function automatic void enter_step(logic [5:0] first);
    logic [5:0] s;
    bit         settled;
    s = first;
    settled = 1'b0;
    while (!settled) begin
      lcd_step = step_t'(s);
      en_lvl   = 1'b0;
      settled  = 1'b1;
      if (s == STEP_IDLE || s > STEP_INIT_ON) begin
        lcd_step  = STEP_IDLE;
        wait_left = '0;
      end else if (s == STEP_POWER || s == STEP_CLR_WAIT || s == STEP_INIT_CLR_WAIT) begin
        wait_left = (s == STEP_POWER) ? lcd_cfg.power_wait : lcd_cfg.clear_wait;
        if (wait_left == 0) begin
          s = following_step(s);
          settled = 1'b0;
        end
      end else if (s >= STEP_NIB_0 && s <= STEP_NIB_3) begin
        rs_lvl   = 1'b0;
        low_half = 1'b0;
        raise_enable(s == STEP_NIB_3 ? NIB_FOUR_BIT : NIB_WAKE);
      end else begin
        case (s)
          STEP_CLR_BYTE, STEP_INIT_CLR_BYTE: held_byte = BYTE_CLEAR;
          STEP_INIT_FUNC: held_byte = BYTE_FUNC_SET;
          STEP_INIT_OFF:  held_byte = BYTE_DISP_OFF;
          STEP_INIT_MODE: held_byte = BYTE_ENTRY;
          STEP_INIT_ON:   held_byte = BYTE_DISP_ON;
          default: ;
        endcase
        if (s != STEP_WRITE) held_sel = 1'b0;
        low_half = 1'b0;
        rs_lvl   = held_sel;
        raise_enable(held_byte[7:4]);
      end
    end
  endfunction

  // One microsecond of sequencer time
  function automatic void advance_tick();
    if (lcd_step == STEP_IDLE) return;
    if (wait_left != 0) wait_left--;
    if (wait_left != 0) return;
    if (en_lvl) begin
      en_lvl = 1'b0;
      if (lcd_step == STEP_NIB_0) begin
        wait_left = lcd_cfg.first_gap;
        if (wait_left == 0) enter_step(following_step(lcd_step));
      end else begin
        wait_left = (lcd_cfg.nibble_gap == 0) ? 16'd1 : lcd_cfg.nibble_gap;
      end
    end else if (sends_byte(lcd_step) && !low_half) begin
      low_half = 1'b1;
      raise_enable(held_byte[3:0]);
    end else begin
      enter_step(following_step(lcd_step));
    end
  endfunction

  function automatic lcd_out_t predict_pins(lcd_in_t it);
    lcd_out_t r;
    logic     dropped;
    dropped = 1'b0;
    if (it.cmd == CMD_TICK) begin
      advance_tick();
    end else if (lcd_step != STEP_IDLE) begin
      dropped = 1'b1;
    end else begin
      case (it.cmd)
        CMD_WRITE: begin
          held_byte = it.data_byte;
          held_sel  = it.register_select;
          enter_step(STEP_WRITE);
        end
        CMD_INIT: enter_step(STEP_POWER);
        default:  enter_step(STEP_CLR_BYTE);
      endcase
    end
    r.rs_pin      = rs_lvl;
    r.enable_pin  = en_lvl;
    r.data_nibble = nib_lvl;
    r.port_nibble = lcd_cfg.mirror_port ? {nib_lvl[0], nib_lvl[1], nib_lvl[2], nib_lvl[3]}
                                        : nib_lvl;
    r.busy_res    = (lcd_step != STEP_IDLE);
    r.rejected    = dropped;
    return r;
  endfunction

  // Driver: predict on each accepted transfer, then offer the next item
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        pin_levels_due.push_back(predict_pins(cmd_item));
        items_taken++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_item  <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void compare_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      if (mismatches < 100) $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(lcd_out_t got);
    lcd_out_t want;
    if (pin_levels_due.size() == 0) begin
      if (mismatches < 100) $error("result transfer with no prediction waiting");
      mismatches++;
      return;
    end
    want = pin_levels_due.pop_front();
    compare_field("rs_pin", {3'd0, want.rs_pin}, {3'd0, got.rs_pin});
    compare_field("enable_pin", {3'd0, want.enable_pin}, {3'd0, got.enable_pin});
    compare_field("data_nibble", want.data_nibble, got.data_nibble);
    compare_field("port_nibble", want.port_nibble, got.port_nibble);
    compare_field("busy_res", {3'd0, want.busy_res}, {3'd0, got.busy_res});
    compare_field("rejected", {3'd0, want.rejected}, {3'd0, got.rejected});
    results_checked++;
    if (got.rejected === 1'b1) drops_seen++;
  endfunction

  // Monitor: check each result transfer, stall at random or for a long hold
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) check_result(res_item);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic queue_item(cmd_t c, logic [7:0] d, logic s);
    lcd_in_t it;
    it.cmd = c;
    it.data_byte = d;
    it.register_select = s;
    cmd_backlog.push_back(it);
  endtask

  task automatic set_reg(logic [CfgIndexWidth-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_MIRROR_PORT:  lcd_cfg.mirror_port  = val[0];
      CFG_ENABLE_WIDTH: lcd_cfg.enable_width = val[7:0];
      CFG_NIBBLE_GAP:   lcd_cfg.nibble_gap   = val;
      CFG_CLEAR_WAIT:   lcd_cfg.clear_wait   = val;
      CFG_POWER_WAIT:   lcd_cfg.power_wait   = val;
      CFG_FIRST_GAP:    lcd_cfg.first_gap    = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(logic mirror, logic [7:0] ew, logic [15:0] gap,
                                logic [15:0] clr, logic [15:0] pwr, logic [15:0] first);
    set_reg(CFG_MIRROR_PORT, {15'd0, mirror});
    set_reg(CFG_ENABLE_WIDTH, {8'd0, ew});
    set_reg(CFG_NIBBLE_GAP, gap);
    set_reg(CFG_CLEAR_WAIT, clr);
    set_reg(CFG_POWER_WAIT, pwr);
    set_reg(CFG_FIRST_GAP, first);
    @(negedge clk);
  endtask

  task automatic random_settings();
    apply_settings(1'($urandom_range(1)), 8'($urandom_range(4)), 16'($urandom_range(6)),
                   16'($urandom_range(12)), 16'($urandom_range(20)),
                   16'($urandom_range(8)));
  endtask

  // Sender pause: nothing queued, nothing offered, nothing owed
  task automatic wait_drained();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || pin_levels_due.size() != 0)
      @(negedge clk);
  endtask

  // Feed ticks until the running sequence ends; noise_pct injects commands while busy
  task automatic run_until_idle(int unsigned noise_pct);
    @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || lcd_step != STEP_IDLE) begin
      if (cmd_backlog.size() == 0 && lcd_step != STEP_IDLE) begin
        if ($urandom_range(99) < noise_pct)
          queue_item(cmd_t'($urandom_range(3, 1)), 8'($urandom_range(255)),
                     1'($urandom_range(1)));
        else
          queue_item(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      @(negedge clk);
    end
  endtask

  // Mostly complete sequences with random content, some idle ticks and dropped commands
  task automatic random_traffic(int unsigned target);
    int unsigned first;
    int unsigned pick;
    first = items_taken;
    while (items_taken - first < target) begin
      pick = $urandom_range(99);
      if (pick < 10)
        repeat ($urandom_range(3, 1))
          queue_item(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (pick < 65)
        queue_item(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (pick < 82)
        queue_item(CMD_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else
        queue_item(CMD_INIT, 8'($urandom_range(255)), 1'($urandom_range(1)));
      run_until_idle(4);
      if ($urandom_range(7) == 0) wait_drained();
    end
  endtask

  initial begin
    reset_predictor();
    send_idle_pct = 30;
    recv_idle_pct = 54;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: idle tick, one write, commands dropped while busy
    queue_item(CMD_TICK, 8'hFF, 1'b1);
    queue_item(CMD_WRITE, 8'hA5, 1'b1);
    queue_item(CMD_CLEAR, 8'h00, 1'b0);
    queue_item(CMD_INIT, 8'h00, 1'b0);
    run_until_idle(0);
    wait_drained();

    // All zero: waits skipped, zero pulse and gap lengths taken as one
    apply_settings(1'b0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(CMD_INIT, 8'h00, 1'b0);
    run_until_idle(0);
    queue_item(CMD_CLEAR, 8'hFF, 1'b1);
    run_until_idle(0);
    queue_item(CMD_WRITE, 8'h00, 1'b0);
    queue_item(CMD_WRITE, 8'hFF, 1'b1);
    run_until_idle(0);
    queue_item(CMD_WRITE, 8'hFF, 1'b1);
    run_until_idle(0);
    queue_item(CMD_TICK, 8'h00, 1'b0);
    wait_drained();

    // Short non-zero timings with mirroring back on
    apply_settings(1'b1, 8'd3, 16'd2, 16'd5, 16'd7, 16'd4);
    queue_item(CMD_INIT, 8'h00, 1'b0);
    queue_item(CMD_WRITE, 8'h3C, 1'b1);
    run_until_idle(0);
    queue_item(CMD_CLEAR, 8'h00, 1'b0);
    run_until_idle(0);
    queue_item(CMD_WRITE, 8'h5A, 1'b1);
    run_until_idle(0);
    wait_drained();

    random_settings();
    random_traffic(15);
    wait_drained();

    // Swap idle rates; long receiver hold while the sender keeps offering
    send_idle_pct = 54;
    recv_idle_pct = 30;
    random_settings();
    queue_item(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)));
    hold_requests++;
    run_until_idle(3);
    random_traffic(15);
    wait_drained();

    // No idling: slower timings on a clear with the init waits at full scale,
    // init dropped while busy, then more random traffic
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(1'b1, 8'd6, 16'd9, 16'd12, 16'hFFFF, 16'hFFFF);
    queue_item(CMD_CLEAR, 8'h00, 1'b0);
    queue_item(CMD_INIT, 8'h00, 1'b0);
    run_until_idle(0);
    wait_drained();
    random_settings();
    random_traffic(15);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Checked %0d results over %0d input transfers, %0d commands dropped while busy.",
             results_checked, items_taken, drops_seen);
    $display("Writes, clears and init ran under reset, zero, short, random and slower timings.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run
  initial begin
    #(12 * 2_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
